### design/cda_pkg.sv
// ============================================================================
// cda_pkg
// Shared types, constants and the microcode program of the calendar date
// advance block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

    // date fields and the running day count
    typedef logic [4:0]  day_t;
    typedef logic [3:0]  month_t;
    typedef logic [15:0] year_t;
    typedef logic [15:0] days_t;
    // year modulo 400, for the century leap rule
    typedef logic [8:0]  ymod_t;

    // microcode step address
    typedef logic [1:0]  step_t;

    // datapath operation of one control word
    typedef enum logic [1:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_WALK,
        UOP_EMIT
    } uop_t;

    // jump condition of one control word
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_WAIT,
        COND_WALK_MORE,
        COND_OUT_BUSY
    } cond_t;

    // control word: jump to target when cond holds, else fall through
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t target;
    } ucode_word_t;

    // status flags from datapath to sequencer
    typedef struct packed {
        logic in_wait;
        logic walk_more;
        logic out_busy;
    } dp_status_t;

    // program step addresses
    localparam step_t STEP_LOAD = 2'd0;
    localparam step_t STEP_WALK = 2'd1;
    localparam step_t STEP_EMIT = 2'd2;
    localparam step_t STEP_WRAP = 2'd3;

    localparam month_t MONTHS_PER_YEAR = 4'd12;
    localparam month_t MONTH_FEB       = 4'd2;

    // date after reset: 2 May 1980
    localparam day_t   RESET_DAY   = 5'd2;
    localparam month_t RESET_MONTH = 4'd5;
    localparam year_t  RESET_YEAR  = 16'd1980;
    localparam ymod_t  RESET_YMOD  = 9'd380;

    localparam ymod_t  YMOD_LAST   = 9'd399;
    localparam ymod_t  YMOD_C1     = 9'd100;
    localparam ymod_t  YMOD_C2     = 9'd200;
    localparam ymod_t  YMOD_C3     = 9'd300;

    // control store
    function automatic ucode_word_t ucode_fetch(input step_t step);
        ucode_word_t w;
        begin
            case (step)
                STEP_LOAD: w = '{op: UOP_LOAD, cond: COND_IN_WAIT,   target: STEP_LOAD};
                STEP_WALK: w = '{op: UOP_WALK, cond: COND_WALK_MORE, target: STEP_WALK};
                STEP_EMIT: w = '{op: UOP_EMIT, cond: COND_OUT_BUSY,  target: STEP_EMIT};
                STEP_WRAP: w = '{op: UOP_NOP,  cond: COND_ALWAYS,    target: STEP_LOAD};
                default:   w = '{op: UOP_NOP,  cond: COND_ALWAYS,    target: STEP_LOAD};
            endcase
            return w;
        end
    endfunction

    // month length; a month code outside 1..12 counts as 31 days
    function automatic day_t month_days(input month_t month, input logic leap);
        day_t d;
        begin
            case (month)
                4'd2:    d = leap ? 5'd29 : 5'd28;
                4'd4:    d = 5'd30;
                4'd6:    d = 5'd30;
                4'd9:    d = 5'd30;
                4'd11:   d = 5'd30;
                default: d = 5'd31;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

### design/cda_seq.sv
// ============================================================================
// cda_seq
// Microcode sequencer: step counter, control store fetch and conditional
// jump on datapath status.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cda_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cda_pkg::dp_status_t  status,
    output cda_pkg::ucode_word_t      uword
);
    import cda_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take_jump;

    // fetch current control word
    assign uword = ucode_fetch(step_reg);

    // jump condition select and next step
    always_comb
    begin
        case (uword.cond)
            COND_ALWAYS:    take_jump = 1'b1;
            COND_IN_WAIT:   take_jump = status.in_wait;
            COND_WALK_MORE: take_jump = status.walk_more;
            COND_OUT_BUSY:  take_jump = status.out_busy;
            default:        take_jump = 1'b1;
        endcase
        step_next = take_jump ? uword.target : step_t'(step_reg + 2'd1);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

### design/cda_dp.sv
// ============================================================================
// cda_dp
// Date datapath: stored date, remaining day count, one month roll per walk
// step, and the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cda_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cda_pkg::ucode_word_t  uword,
    output cda_pkg::dp_status_t        status,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [15:0]           days_to_advance,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [4:0]                 day_out,
    output logic [3:0]                 month_out,
    output logic [15:0]                year_out
);
    import cda_pkg::*;

    day_t   day_reg,   day_next;
    month_t month_reg, month_next;
    year_t  year_reg,  year_next;
    ymod_t  ymod_reg,  ymod_next;
    days_t  left_reg,  left_next;
    logic   out_valid_reg, out_valid_next;
    day_t   day_out_reg;
    month_t month_out_reg;
    year_t  year_out_reg;

    logic        leap;
    day_t        dim;
    logic [16:0] day_sum;
    logic        fits;
    day_t        to_next;
    days_t       left_rem;
    logic        year_end;
    logic        out_busy;
    logic        emit_go;

    // month length for the stored date
    assign leap = (year_reg[1:0] == 2'b00) && (ymod_reg != YMOD_C1)
                  && (ymod_reg != YMOD_C2) && (ymod_reg != YMOD_C3);
    assign dim  = month_days(month_reg, leap);

    // fit test and days to the first of the next month
    assign day_sum  = {12'd0, day_reg} + {1'b0, left_reg};
    assign fits     = (day_sum <= {12'd0, dim});
    assign to_next  = (day_reg <= dim) ? day_t'(dim - day_reg + 5'd1) : 5'd1;
    assign left_rem = ({11'd0, to_next} < left_reg) ? days_t'(left_reg - {11'd0, to_next})
                                                    : 16'd0;
    assign year_end = !((month_reg >= 4'd1) && (month_reg < MONTHS_PER_YEAR));

    // handshake and status to the sequencer
    assign out_busy         = out_valid_reg && !out_ready;
    assign emit_go          = (uword.op == UOP_EMIT) && !out_busy;
    assign in_ready         = (uword.op == UOP_LOAD);
    assign status.in_wait   = !in_valid;
    assign status.walk_more = !fits && (left_rem != 16'd0);
    assign status.out_busy  = out_busy;

    assign out_valid = out_valid_reg;
    assign day_out   = day_out_reg;
    assign month_out = month_out_reg;
    assign year_out  = year_out_reg;

    // next date, remaining count and result flag
    always_comb
    begin
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        ymod_next      = ymod_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (uword.op)
            UOP_LOAD:
            begin
                left_next = days_to_advance;
            end
            UOP_WALK:
            begin
                if (fits)
                begin
                    day_next  = day_t'(day_sum);
                    left_next = 16'd0;
                end
                else
                begin
                    left_next = left_rem;
                    day_next  = 5'd1;
                    if (!year_end)
                    begin
                        month_next = month_t'(month_reg + 4'd1);
                    end
                    else
                    begin
                        month_next = 4'd1;
                        year_next  = year_t'(year_reg + 16'd1);
                        if (year_reg == 16'hFFFF)
                        begin
                            ymod_next = 9'd0;
                        end
                        else if (ymod_reg == YMOD_LAST)
                        begin
                            ymod_next = 9'd0;
                        end
                        else
                        begin
                            ymod_next = ymod_t'(ymod_reg + 9'd1);
                        end
                    end
                end
            end
            UOP_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // date state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg       <= RESET_DAY;
            month_reg     <= RESET_MONTH;
            year_reg      <= RESET_YEAR;
            ymod_reg      <= RESET_YMOD;
            left_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            ymod_reg      <= ymod_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            day_out_reg   <= day_reg;
            month_out_reg <= month_reg;
            year_out_reg  <= year_reg;
        end
    end

endmodule

`default_nettype wire

### design/calendar_date_advance_top.sv
// ============================================================================
// calendar_date_advance_top
// Advances a stored calendar date by a day count per input beat.
// ============================================================================
// path: an accepted input beat runs walk steps, one per month touched
//   (at least 1), then the emit step registers the result beat
// flow: one item at a time; the next input beat is taken after the emit
//   and wrap steps, and later while the previous result beat is still held
// reset: date returns to 2 May 1980, no result pending
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_advance_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] days_to_advance,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       day_out,
    output logic [3:0]       month_out,
    output logic [15:0]      year_out
);
    import cda_pkg::*;

    ucode_word_t uword;
    dp_status_t  status;

    // microcode sequencer
    cda_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    // date datapath
    cda_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .uword           (uword),
        .status          (status),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .days_to_advance (days_to_advance),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .day_out         (day_out),
        .month_out       (month_out),
        .year_out        (year_out)
    );

    // one item in flight: no new beat right after an accepted one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

    // result month always in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_out >= 4'd1 && month_out <= MONTHS_PER_YEAR))
    else $error("result month out of range");

    // result day never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (day_out != 5'd0))
    else $error("result day is zero");

endmodule

`default_nettype wire
